### sv/vt_pkg.sv
// Shared types, constants and widths for the vertex transform block.
`timescale 1ns / 1ps
package vt_pkg;

    // Fixed-point format of one vector or matrix element.
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    // Width of the payload fields on the ports.
    localparam int FIELD_WIDTH = 32;

    // Configuration register file.
    localparam int NUM_REGS    = 8;
    localparam int REG_WIDTH   = 64;
    localparam int IDX_WIDTH   = 3;
    localparam int HALF_WIDTH  = REG_WIDTH / 2;

    // Datapath widths.
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int NUM_WIDTH   = DATA_WIDTH + FRAC_BITS;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;

    // Operation codes.
    localparam logic OP_HOMOG = 1'b0;
    localparam logic OP_POINT = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] t_elem;

    localparam t_elem ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_elem ELEM_ONE = t_elem'(1) <<< FRAC_BITS;

    // Register reset values: identity matrix.
    localparam logic [REG_WIDTH-1:0] ONE_LO = REG_WIDTH'(ELEM_ONE);
    localparam logic [REG_WIDTH-1:0] ONE_HI = ONE_LO << HALF_WIDTH;
    localparam logic [REG_WIDTH-1:0] MAT_RESET [NUM_REGS] = '{
        ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
    };

    typedef struct packed {
        logic                           op;
        logic signed [FIELD_WIDTH-1:0]  in_x;
        logic signed [FIELD_WIDTH-1:0]  in_y;
        logic signed [FIELD_WIDTH-1:0]  in_z;
        logic signed [FIELD_WIDTH-1:0]  in_w;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0]  out_x;
        logic signed [FIELD_WIDTH-1:0]  out_y;
        logic signed [FIELD_WIDTH-1:0]  out_z;
        logic signed [FIELD_WIDTH-1:0]  out_w;
        logic                           divide_by_zero;
        logic                           saturated;
    } t_out;

    // A classified vertex: element 3 is w, already forced to one for points.
    typedef struct packed {
        logic        point;
        t_elem [3:0] v;
    } t_job;

    // Matrix elements indexed [row][col].
    typedef t_elem [3:0][3:0] t_mat;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### sv/vt_front.sv
// Front part: accepts input beats, classifies them and pushes them to the queue.
`timescale 1ns / 1ps
module vt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  vt_pkg::t_in     i_in,
    input  vt_pkg::t_q_stat i_q,
    output logic            o_push,
    output vt_pkg::t_job    o_job
);

    logic         r_valid;
    logic         n_valid;
    vt_pkg::t_job r_job;
    vt_pkg::t_job n_job;
    logic         accept;

    assign o_stall = r_valid && i_q.full;
    assign o_push  = r_valid && !i_q.full;
    assign accept  = i_valid && !o_stall;
    assign o_job   = r_job;

    // Classify: a point takes w as exactly one.
    always_comb begin
        n_job.point = (i_in.op == vt_pkg::OP_POINT);
        n_job.v[0]  = vt_pkg::t_elem'(i_in.in_x[vt_pkg::DATA_WIDTH-1:0]);
        n_job.v[1]  = vt_pkg::t_elem'(i_in.in_y[vt_pkg::DATA_WIDTH-1:0]);
        n_job.v[2]  = vt_pkg::t_elem'(i_in.in_z[vt_pkg::DATA_WIDTH-1:0]);
        n_job.v[3]  = n_job.point ? vt_pkg::ELEM_ONE
                                  : vt_pkg::t_elem'(i_in.in_w[vt_pkg::DATA_WIDTH-1:0]);
    end

    // Holding register is refilled on accept and emptied on push.
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

### sv/vt_fifo.sv
// Short queue of classified vertices between the front and back parts.
`timescale 1ns / 1ps
module vt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vt_pkg::t_job    i_job,
    input  logic            i_pop,
    output vt_pkg::t_job    o_job,
    output vt_pkg::t_q_stat o_stat
);

    vt_pkg::t_job               r_mem [vt_pkg::FIFO_DEPTH];
    logic [vt_pkg::FIFO_AW-1:0] r_wp;
    logic [vt_pkg::FIFO_AW-1:0] r_rp;
    logic [vt_pkg::FIFO_AW:0]   r_cnt;
    logic [vt_pkg::FIFO_AW:0]   n_cnt;

    assign o_stat.full  = (r_cnt == (vt_pkg::FIFO_AW+1)'(vt_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rp];

    // Occupancy follows push and pop.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### sv/vt_back.sv
// Back part: multiply, row sums, saturation and the pipelined perspective divide.
`timescale 1ns / 1ps
module vt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vt_pkg::t_mat    i_mat,
    input  vt_pkg::t_job    i_job,
    input  vt_pkg::t_q_stat i_q,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output vt_pkg::t_out    o_out
);

    localparam int DW = vt_pkg::DATA_WIDTH;
    localparam int PW = vt_pkg::PROD_WIDTH;
    localparam int SW = vt_pkg::SUM_WIDTH;
    localparam int NW = vt_pkg::NUM_WIDTH;
    localparam int FB = vt_pkg::FRAC_BITS;

    localparam logic [NW-1:0] Q_POS = NW'({1'b0, {(DW-1){1'b1}}});
    localparam logic [NW-1:0] Q_NEG = Q_POS + 1'b1;

    // One divider stage: three lanes share the divisor magnitude.
    typedef struct packed {
        logic                      point;
        logic                      dz;
        logic                      sat;
        vt_pkg::t_elem [3:0]       r;
        logic [DW-1:0]             dmag;
        logic [2:0]                neg;
        logic [2:0][NW-1:0]        num;
        logic [2:0][DW-1:0]        rem;
        logic [2:0][NW-1:0]        q;
    } t_dst;

    function automatic t_dst div_step(input t_dst d);
        t_dst       res;
        logic [DW:0] sh;
        logic        qb;
        res = d;
        for (int l = 0; l < 3; l++) begin
            sh = {d.rem[l], d.num[l][NW-1]};
            qb = 1'b0;
            if (sh >= {1'b0, d.dmag}) begin
                sh = sh - {1'b0, d.dmag};
                qb = 1'b1;
            end
            res.rem[l] = sh[DW-1:0];
            res.num[l] = d.num[l] << 1;
            res.q[l]   = {d.q[l][NW-2:0], qb};
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] mag(input vt_pkg::t_elem x);
        logic [DW-1:0] u;
        u = x;
        return x[DW-1] ? (~u + 1'b1) : u;
    endfunction

    logic ce;
    logic r_out_valid;
    vt_pkg::t_out r_out;

    // The whole pipeline moves when the output register can take a beat.
    assign ce      = !r_out_valid || !i_stall;
    assign o_pop   = ce && !i_q.empty;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Stage 1: sixteen products.
    logic                   r1_v;
    logic                   r1_point;
    logic signed [PW-1:0]   r1_p [4][4];

    // Stage 2: pairwise sums per row.
    logic                   r2_v;
    logic                   r2_point;
    logic signed [SW-1:0]   r2_a [4];
    logic signed [SW-1:0]   r2_b [4];

    // Stage 3: floored and clipped rows.
    logic                   r3_v;
    logic                   r3_point;
    logic                   r3_sat;
    vt_pkg::t_elem          r3_r [4];
    vt_pkg::t_elem          n3_r [4];
    logic                   n3_sat;

    // Divider pipeline: entry 0 is the setup stage.
    logic [NW:0]            r_dv;
    t_dst                   r_ds [NW+1];
    t_dst                   n_ds [NW+1];

    vt_pkg::t_out           n_out;

    // Row sum, floor to the fraction point and clip.
    always_comb begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] sh;
        n3_sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            sum = r2_a[r] + r2_b[r];
            sh  = sum >>> FB;
            if (sh > SW'(vt_pkg::ELEM_MAX)) begin
                n3_r[r] = vt_pkg::ELEM_MAX;
                n3_sat  = 1'b1;
            end else if (sh < SW'(vt_pkg::ELEM_MIN)) begin
                n3_r[r] = vt_pkg::ELEM_MIN;
                n3_sat  = 1'b1;
            end else begin
                n3_r[r] = sh[DW-1:0];
            end
        end
    end

    // Divider setup and one quotient bit per stage.
    always_comb begin
        n_ds[0].point = r3_point;
        n_ds[0].sat   = r3_sat;
        n_ds[0].dz    = r3_point && (r3_r[3] == '0);
        for (int r = 0; r < 4; r++) begin
            n_ds[0].r[r] = r3_r[r];
        end
        n_ds[0].dmag = mag(r3_r[3]);
        for (int l = 0; l < 3; l++) begin
            n_ds[0].neg[l] = r3_r[l][DW-1] ^ r3_r[3][DW-1];
            n_ds[0].num[l] = {mag(r3_r[l]), {FB{1'b0}}};
            n_ds[0].rem[l] = '0;
            n_ds[0].q[l]   = '0;
        end
        for (int s = 0; s < NW; s++) begin
            n_ds[s+1] = div_step(r_ds[s]);
        end
    end

    // Result selection: homogeneous pass, zero w, or clipped quotient.
    always_comb begin
        t_dst          d;
        vt_pkg::t_elem res [3];
        logic          sat;
        logic [NW-1:0] qn;
        d   = r_ds[NW];
        sat = d.sat;
        for (int l = 0; l < 3; l++) begin
            qn = ~d.q[l] + 1'b1;
            if (!d.point) begin
                res[l] = d.r[l];
            end else if (d.dz) begin
                res[l] = d.r[l][DW-1] ? vt_pkg::ELEM_MIN : vt_pkg::ELEM_MAX;
                sat    = 1'b1;
            end else if (!d.neg[l] && (d.q[l] > Q_POS)) begin
                res[l] = vt_pkg::ELEM_MAX;
                sat    = 1'b1;
            end else if (d.neg[l] && (d.q[l] > Q_NEG)) begin
                res[l] = vt_pkg::ELEM_MIN;
                sat    = 1'b1;
            end else if (d.neg[l]) begin
                res[l] = qn[DW-1:0];
            end else begin
                res[l] = d.q[l][DW-1:0];
            end
        end
        n_out.out_x          = vt_pkg::FIELD_WIDTH'(res[0]);
        n_out.out_y          = vt_pkg::FIELD_WIDTH'(res[1]);
        n_out.out_z          = vt_pkg::FIELD_WIDTH'(res[2]);
        n_out.out_w          = vt_pkg::FIELD_WIDTH'(d.r[3]);
        n_out.divide_by_zero = d.dz;
        n_out.saturated      = sat;
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_dv        <= '0;
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r1_v        <= o_pop;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r_dv        <= {r_dv[NW-1:0], r3_v};
            r_out_valid <= r_dv[NW];
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_point <= i_job.point;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r1_p[r][c] <= i_mat[r][c] * i_job.v[c];
                end
            end
            r2_point <= r1_point;
            for (int r = 0; r < 4; r++) begin
                r2_a[r] <= SW'(r1_p[r][0]) + SW'(r1_p[r][1]);
                r2_b[r] <= SW'(r1_p[r][2]) + SW'(r1_p[r][3]);
            end
            r3_point <= r2_point;
            r3_sat   <= n3_sat;
            for (int r = 0; r < 4; r++) begin
                r3_r[r] <= n3_r[r];
            end
            for (int s = 0; s <= NW; s++) begin
                r_ds[s] <= n_ds[s];
            end
            r_out <= n_out;
        end
    end

endmodule

### sv/vertex_transform_4x4.sv
// Top level of the 4x4 homogeneous vertex transform.
`timescale 1ns / 1ps
// Usage:
// The input channel (i_valid, o_stall, i_in) takes one vertex per beat: op selects
// a homogeneous transform or a point transform with w set to one and a divide by
// the transformed w. The output channel (o_valid, i_stall, o_out) returns one
// result beat per vertex, in order.
// The matrix lives in eight 64-bit registers written through i_cfg_we, i_cfg_idx
// and i_cfg_data; write them only while no vertex is in flight.
// Throughput is one vertex per cycle while the receiver does not stall. The accepting
// edge loads the input register; the Q16.16 vertex then passes through the queue,
// the product, pairwise-sum and clipped-row stages, the setup and quotient-bit
// stages of the restoring divider, and the output register.
// When the receiver stalls, the back pipeline freezes, the queue fills and then
// o_stall rises; no beat is lost or repeated.
// Reset empties the pipeline and the queue and loads the identity matrix.
module vertex_transform_4x4 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  vt_pkg::t_in                      i_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output vt_pkg::t_out                     o_out,
    input  logic                             i_cfg_we,
    input  logic [vt_pkg::IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [vt_pkg::REG_WIDTH-1:0]     i_cfg_data
);

    logic [vt_pkg::REG_WIDTH-1:0] r_regs [vt_pkg::NUM_REGS];
    vt_pkg::t_mat                 w_mat;
    vt_pkg::t_q_stat              w_q;
    vt_pkg::t_job                 w_push_job;
    vt_pkg::t_job                 w_head_job;
    logic                         w_push;
    logic                         w_pop;

    // Matrix register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= vt_pkg::MAT_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Unpack column-major registers into [row][col] elements.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_mat[r][c] = vt_pkg::t_elem'(
                    r_regs[c*2 + r/2][(r%2)*vt_pkg::HALF_WIDTH +: vt_pkg::DATA_WIDTH]);
            end
        end
    end

    vt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .i_q     (w_q),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    vt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q)
    );

    vt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (w_mat),
        .i_job   (w_head_job),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.full |-> !w_push)
        else $error("queue push while full");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q.empty)
        else $error("queue pop while empty");

    // A zero divisor always reports saturation.
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.divide_by_zero) |-> o_out.saturated)
        else $error("divide by zero without saturation flag");

endmodule

### test/vertex_transform_4x4_tb.sv
// Self-checking testbench for the 4x4 vertex transform: directed and random vertices.
`timescale 1ns / 1ps
module vertex_transform_4x4_tb;

    localparam int LATENCY     = vt_pkg::FRAC_BITS + vt_pkg::DATA_WIDTH + 7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HI_VAL      = 2147483647;
    localparam int LO_VAL      = -2147483648;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    vt_pkg::t_in                  i_in;
    logic                         o_valid;
    logic                         i_stall;
    vt_pkg::t_out                 o_out;
    logic                         i_cfg_we;
    logic [vt_pkg::IDX_WIDTH-1:0] i_cfg_idx;
    logic [vt_pkg::REG_WIDTH-1:0] i_cfg_data;

    // Predictor copy of the matrix registers.
    logic [vt_pkg::REG_WIDTH-1:0] matrix_regs [vt_pkg::NUM_REGS];
    vt_pkg::t_out                 expected_vertices [$];
    int                           error_count;
    int                           result_count;
    int                           cycle_count = 0;
    int                           send_idle_pct;
    int                           recv_idle_pct;

    vertex_transform_4x4 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    // Clip a value to the element range and note any clipping.
    function automatic longint clip_elem(input longint v, inout bit sat);
        if (v > HI_VAL) begin
            sat = 1'b1;
            return HI_VAL;
        end
        if (v < LO_VAL) begin
            sat = 1'b1;
            return LO_VAL;
        end
        return v;
    endfunction

    function automatic longint matrix_entry(input int col, input int row);
        logic [vt_pkg::REG_WIDTH-1:0] r;
        r = matrix_regs[col * 2 + row / 2];
        return longint'($signed(row[0] ? r[63:32] : r[31:0]));
    endfunction

    // One vertex through the matrix, with the point-mode divide.
    function automatic vt_pkg::t_out transform_vertex(input vt_pkg::t_in vin);
        longint v [4];
        longint r [4];
        logic signed [vt_pkg::SUM_WIDTH-1:0] acc;
        logic signed [127:0] num;
        bit sat;
        bit dz;
        bit point;
        vt_pkg::t_out res;
        sat = 1'b0;
        dz = 1'b0;
        point = (vin.op == vt_pkg::OP_POINT);
        v[0] = longint'(vin.in_x);
        v[1] = longint'(vin.in_y);
        v[2] = longint'(vin.in_z);
        v[3] = point ? (longint'(1) <<< vt_pkg::FRAC_BITS) : longint'(vin.in_w);
        for (int row = 0; row < 4; row++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc += vt_pkg::SUM_WIDTH'(matrix_entry(c, row) * v[c]);
            end
            acc = acc >>> vt_pkg::FRAC_BITS;
            if (acc > HI_VAL) begin
                sat = 1'b1;
                r[row] = HI_VAL;
            end else if (acc < LO_VAL) begin
                sat = 1'b1;
                r[row] = LO_VAL;
            end else begin
                r[row] = longint'(acc);
            end
        end
        if (point) begin
            if (r[3] == 0) begin
                dz = 1'b1;
                sat = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r[i] = (r[i] < 0) ? LO_VAL : HI_VAL;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r[i] = clip_elem((r[i] <<< vt_pkg::FRAC_BITS) / r[3], sat);
                end
            end
        end
        res.out_x = r[0][31:0];
        res.out_y = r[1][31:0];
        res.out_z = r[2][31:0];
        res.out_w = r[3][31:0];
        res.divide_by_zero = dz;
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Write one matrix register; the block must be idle.
    task automatic write_matrix_reg(input int idx, input logic [vt_pkg::REG_WIDTH-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= vt_pkg::IDX_WIDTH'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
        matrix_regs[idx] = data;
    endtask

    task automatic load_matrix(input logic [vt_pkg::REG_WIDTH-1:0] m [vt_pkg::NUM_REGS]);
        for (int i = 0; i < vt_pkg::NUM_REGS; i++) begin
            write_matrix_reg(i, m[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Send one vertex beat, with random gaps before it.
    task automatic send_vertex(input vt_pkg::t_in vin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= vin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        expected_vertices.push_back(transform_vertex(vin));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_vertices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(8 << 16)) - (4 << 16));
            3: return 32'(int'($urandom_range(512)) - 256);
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic vt_pkg::t_in rand_vertex();
        vt_pkg::t_in vin;
        vin.op   = $urandom_range(1) ? vt_pkg::OP_POINT : vt_pkg::OP_HOMOG;
        vin.in_x = rand_elem();
        vin.in_y = rand_elem();
        vin.in_z = rand_elem();
        vin.in_w = rand_elem();
        return vin;
    endfunction

    function automatic logic [vt_pkg::REG_WIDTH-1:0] rand_reg(input int mode);
        if (mode == 0) begin
            return {$urandom, $urandom};
        end
        return {32'(int'($urandom_range(4 << 16)) - (2 << 16)),
                32'(int'($urandom_range(4 << 16)) - (2 << 16))};
    endfunction

    // Directed corners under the reset identity, a zero bottom row and extreme matrices.
    task automatic test_directed();
        vt_pkg::t_in vin;
        logic [vt_pkg::REG_WIDTH-1:0] m [vt_pkg::NUM_REGS];
        logic [31:0] corners [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1,
                                     32'hFFFF_FFFF};
        for (int i = 0; i < 5; i++) begin
            vin = '{op: vt_pkg::OP_HOMOG, in_x: corners[i], in_y: corners[(i + 1) % 5],
                    in_z: corners[(i + 2) % 5], in_w: corners[(i + 3) % 5]};
            send_vertex(vin);
            vin.op = vt_pkg::OP_POINT;
            send_vertex(vin);
        end
        drain_results();
        // Zero bottom row makes every point divide by zero, with all signs.
        m = '{64'h0000_0000_0001_0000, '0, 64'h0001_0000_0000_0000, '0,
              '0, 64'h0000_0000_0001_0000, '0, '0};
        load_matrix(m);
        for (int i = 0; i < 5; i++) begin
            vin = '{op: vt_pkg::OP_POINT, in_x: corners[i], in_y: corners[(i + 2) % 5],
                    in_z: 32'h0, in_w: corners[i]};
            send_vertex(vin);
        end
        drain_results();
        // Every entry at the most positive and then most negative value.
        for (int i = 0; i < vt_pkg::NUM_REGS; i++) m[i] = 64'h7FFF_FFFF_7FFF_FFFF;
        load_matrix(m);
        for (int i = 0; i < 3; i++) begin
            vin = '{op: (i == 1) ? vt_pkg::OP_POINT : vt_pkg::OP_HOMOG, in_x: corners[i],
                    in_y: corners[i], in_z: corners[i], in_w: corners[i]};
            send_vertex(vin);
        end
        drain_results();
        for (int i = 0; i < vt_pkg::NUM_REGS; i++) m[i] = 64'h8000_0000_8000_0000;
        load_matrix(m);
        for (int i = 0; i < 3; i++) begin
            vin = '{op: (i == 1) ? vt_pkg::OP_POINT : vt_pkg::OP_HOMOG, in_x: corners[i],
                    in_y: corners[i + 1], in_z: corners[i], in_w: corners[i + 2]};
            send_vertex(vin);
        end
        drain_results();
    endtask

    // Random vertices over a series of random matrices.
    task automatic test_random(input int phases, input int per_phase);
        logic [vt_pkg::REG_WIDTH-1:0] m [vt_pkg::NUM_REGS];
        for (int p = 0; p < phases; p++) begin
            for (int i = 0; i < vt_pkg::NUM_REGS; i++) begin
                m[i] = rand_reg(p % 3);
            end
            // Small w row now and then so that point divides overflow or hit zero.
            if (p % 4 == 3) begin
                m[1][63:32] = '0;
                m[3][63:32] = '0;
                m[5][63:32] = '0;
                m[7][63:32] = 32'($urandom_range(3));
            end
            load_matrix(m);
            for (int n = 0; n < per_phase; n++) begin
                send_vertex(rand_vertex());
            end
            drain_results();
        end
    endtask

    // Receiver side: random stalls and the result check.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        vt_pkg::t_out want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_vertices.size() == 0) begin
                $display("Unexpected result beat %0d", result_count);
                error_count++;
            end else begin
                want = expected_vertices.pop_front();
                if (o_out.out_x !== want.out_x) report_mismatch("out_x", o_out.out_x, want.out_x);
                if (o_out.out_y !== want.out_y) report_mismatch("out_y", o_out.out_y, want.out_y);
                if (o_out.out_z !== want.out_z) report_mismatch("out_z", o_out.out_z, want.out_z);
                if (o_out.out_w !== want.out_w) report_mismatch("out_w", o_out.out_w, want.out_w);
                if (o_out.divide_by_zero !== want.divide_by_zero) begin
                    report_mismatch("divide_by_zero", o_out.divide_by_zero, want.divide_by_zero);
                end
                if (o_out.saturated !== want.saturated) begin
                    report_mismatch("saturated", o_out.saturated, want.saturated);
                end
            end
            result_count++;
        end
    end

    initial begin
        error_count   = 0;
        result_count  = 0;
        send_idle_pct = 24;
        recv_idle_pct = 45;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < vt_pkg::NUM_REGS; i++) matrix_regs[i] = vt_pkg::MAT_RESET[i];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(8, 85);
        send_idle_pct = 45;
        recv_idle_pct = 24;
        test_random(8, 85);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(8, 85);

        $display("Covered %0d result beats: corner vertices, zero w, extreme and random",
                 result_count);
        $display("matrices, both modes, under sender and receiver idling and at full rate.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
sv/vt_pkg.sv
sv/vt_front.sv
sv/vt_fifo.sv
sv/vt_back.sv
sv/vertex_transform_4x4.sv
test/vertex_transform_4x4_tb.sv
